// File: rtl/assert_macros.svh
// Assertion macros shared by the cache RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only out of reset
`define SALC_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("salc assertion failed");

// checked on every edge, reset included
`define SALC_ASSERT_ALL(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("salc assertion failed");

`endif

// File: rtl/salc_pkg.sv
// Shared types and constants of the set-associative LRU cache model
`default_nettype none
package salc_pkg;

  localparam int MAX_SET_BITS_D = 6;
  localparam int MAX_WAYS_D     = 8;
  localparam int TAG_WIDTH_D    = 32;
  localparam int ADDR_WIDTH_D   = 64;

  localparam int KIND_W       = 2;
  localparam int OUTCOME_W    = 2;
  localparam int WAY_OUT_W    = 3;
  localparam int COUNT_W      = 32;
  localparam int AGE_W        = 32;
  localparam int SET_BITS_W   = 3;
  localparam int WAYS_W       = 4;
  localparam int BLOCK_BITS_W = 6;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 6;
  // way index wide enough for the largest supported way count
  localparam int MAX_WAY_IDX_W = 5;

  localparam logic [SET_BITS_W-1:0]   SET_BITS_RST   = 3'd4;
  localparam logic [WAYS_W-1:0]       WAYS_RST       = 4'd1;
  localparam logic [BLOCK_BITS_W-1:0] BLOCK_BITS_RST = 6'd4;

  typedef enum logic [KIND_W-1:0] {
    KIND_LOAD   = 2'd0,
    KIND_STORE  = 2'd1,
    KIND_MODIFY = 2'd2,
    KIND_NONE   = 2'd3
  } kind_t;

  typedef enum logic [OUTCOME_W-1:0] {
    OUT_HIT   = 2'd0,
    OUT_FILL  = 2'd1,
    OUT_EVICT = 2'd2
  } outcome_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SET_BITS   = 2'd0,
    CFG_WAYS       = 2'd1,
    CFG_BLOCK_BITS = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    outcome_t                   outcome;
    logic [MAX_WAY_IDX_W-1:0]   way;
  } pick_t;

endpackage
`default_nettype wire

// File: rtl/salc_req_if.sv
// Access item channel: kind and byte address
`default_nettype none
interface salc_req_if #(
  parameter int ADDR_WIDTH = salc_pkg::ADDR_WIDTH_D
);
  logic                        valid;
  logic                        ready;
  logic [salc_pkg::KIND_W-1:0] kind;
  logic [ADDR_WIDTH-1:0]       address;

  modport source(output valid, kind, address, input ready);
  modport sink(input valid, kind, address, output ready);
endinterface
`default_nettype wire

// File: rtl/salc_rsp_if.sv
// Result item channel: outcome, way and running totals
`default_nettype none
interface salc_rsp_if;
  logic                           valid;
  logic                           ready;
  logic [salc_pkg::OUTCOME_W-1:0] outcome;
  logic [salc_pkg::WAY_OUT_W-1:0] way_used;
  logic                           last;
  logic [salc_pkg::COUNT_W-1:0]   hit_total;
  logic [salc_pkg::COUNT_W-1:0]   miss_total;
  logic [salc_pkg::COUNT_W-1:0]   eviction_total;

  modport source(output valid, outcome, way_used, last, hit_total, miss_total,
                 eviction_total, input ready);
  modport sink(input valid, outcome, way_used, last, hit_total, miss_total,
               eviction_total, output ready);
endinterface
`default_nettype wire

// File: rtl/salc_ram.sv
// Generic single-port-write, registered-read RAM
`default_nettype none
module salc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;
endmodule
`default_nettype wire

// File: rtl/salc_pick.sv
// Way selection for one set: hit search, first empty way, LRU victim
`default_nettype none
module salc_pick #(
  parameter int MAX_WAYS  = salc_pkg::MAX_WAYS_D,
  parameter int TAG_WIDTH = salc_pkg::TAG_WIDTH_D
) (
  input  logic [MAX_WAYS-1:0]                         valid,
  input  logic [MAX_WAYS-1:0][TAG_WIDTH-1:0]          tags,
  input  logic [MAX_WAYS-1:0][salc_pkg::AGE_W-1:0]    ages,
  input  logic [TAG_WIDTH-1:0]                        tag,
  input  logic [$clog2(MAX_WAYS+1)-1:0]               ways,
  output salc_pkg::pick_t                             pick
);
  import salc_pkg::*;

  localparam int WCNT_W = $clog2(MAX_WAYS + 1);

  logic [MAX_WAYS-1:0]      in_use;
  logic [MAX_WAYS-1:0]      hit_vec;
  logic [MAX_WAYS-1:0]      inv_vec;
  logic [MAX_WAYS-1:0]      old_vec;
  logic [MAX_WAY_IDX_W-1:0] hit_way;
  logic [MAX_WAY_IDX_W-1:0] inv_way;
  logic [MAX_WAY_IDX_W-1:0] old_way;

  // compare matrix: a way is the victim if it is strictly older than every
  // lower way and no newer than every higher way
  always_comb begin
    for (int w = 0; w < MAX_WAYS; w++) begin
      in_use[w]  = WCNT_W'(w) < ways;
      hit_vec[w] = in_use[w] && valid[w] && (tags[w] == tag);
      inv_vec[w] = in_use[w] && !valid[w];
    end
    for (int w = 0; w < MAX_WAYS; w++) begin
      old_vec[w] = in_use[w];
      for (int j = 0; j < MAX_WAYS; j++) begin
        if (j < w && in_use[j] && !(ages[w] < ages[j])) begin
          old_vec[w] = 1'b0;
        end
        if (j > w && in_use[j] && !(ages[w] <= ages[j])) begin
          old_vec[w] = 1'b0;
        end
      end
    end
  end

  always_comb begin
    hit_way = '0;
    inv_way = '0;
    old_way = '0;
    for (int w = MAX_WAYS - 1; w >= 0; w--) begin
      if (hit_vec[w]) hit_way = MAX_WAY_IDX_W'(w);
      if (inv_vec[w]) inv_way = MAX_WAY_IDX_W'(w);
      if (old_vec[w]) old_way = MAX_WAY_IDX_W'(w);
    end
  end

  always_comb begin
    priority if (|hit_vec) begin
      pick.outcome = OUT_HIT;
      pick.way     = hit_way;
    end else if (|inv_vec) begin
      pick.outcome = OUT_FILL;
      pick.way     = inv_way;
    end else begin
      pick.outcome = OUT_EVICT;
      pick.way     = old_way;
    end
  end
endmodule
`default_nettype wire

// File: rtl/set_assoc_lru_cache_sim.sv
// Tag-only set-associative cache with LRU replacement. Each set is one row
// of a registered-read RAM holding valid, tag and age stamp for every way; a
// per-set flag, cleared at reset, marks rows never written, which read as
// empty. An access reads the row (on the accept edge), picks the way in the
// next cycle and then writes the row back once the result register is free,
// loading the result register at the same time. A load or store is one
// access, a modify two (its second access rereads the row after the first
// write); kind 3 is accepted but gives no result. The next item is accepted
// in the cycle after the last write-back, while the result may still wait to
// be taken; a write-back waits only while the result register is still full.
// Configuration is to be written through cfg_we/cfg_index/cfg_wdata only while idle; the block does not enforce it.
`default_nettype none
module set_assoc_lru_cache_sim #(
  parameter int MAX_SET_BITS = salc_pkg::MAX_SET_BITS_D,
  parameter int MAX_WAYS     = salc_pkg::MAX_WAYS_D,
  parameter int TAG_WIDTH    = salc_pkg::TAG_WIDTH_D,
  parameter int ADDR_WIDTH   = salc_pkg::ADDR_WIDTH_D
) (
  input  logic                              clk,
  input  logic                              rst_n,
  salc_req_if.sink                          in_req,
  salc_rsp_if.source                        out_rsp,
  input  logic                              cfg_we,
  input  logic [salc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [salc_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import salc_pkg::*;
  `include "assert_macros.svh"

  localparam int NUM_SETS = 1 << MAX_SET_BITS;
  localparam int SET_W    = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
  localparam int WCNT_W   = $clog2(MAX_WAYS + 1);
  localparam int SB_W     = $clog2(MAX_SET_BITS + 1) > 0 ? $clog2(MAX_SET_BITS + 1) : 1;
  localparam int SHIFT_W  = 7;
  localparam int LINE_W   = 1 + TAG_WIDTH + AGE_W;
  localparam int ROW_W    = MAX_WAYS * LINE_W;

  typedef enum logic [1:0] {S_IDLE, S_READ, S_EVAL, S_WRITE} state_t;

  // configuration
  logic [SET_BITS_W-1:0]   set_bits_r;
  logic [WAYS_W-1:0]       ways_r;
  logic [BLOCK_BITS_W-1:0] block_bits_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      set_bits_r   <= SET_BITS_RST;
      ways_r       <= WAYS_RST;
      block_bits_r <= BLOCK_BITS_RST;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_SET_BITS:   set_bits_r   <= SET_BITS_W'(cfg_wdata);
        CFG_WAYS:       ways_r       <= WAYS_W'(cfg_wdata);
        CFG_BLOCK_BITS: block_bits_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  logic [SB_W-1:0]   sb_eff;
  logic [WCNT_W-1:0] ways_eff;

  always_comb begin
    if (int'(set_bits_r) > MAX_SET_BITS) sb_eff = SB_W'(MAX_SET_BITS);
    else                                 sb_eff = SB_W'(set_bits_r);
    priority if (ways_r == '0)               ways_eff = WCNT_W'(1);
    else if (int'(ways_r) > MAX_WAYS)        ways_eff = WCNT_W'(MAX_WAYS);
    else                                     ways_eff = WCNT_W'(ways_r);
  end

  // address split; shifts past the address width give zero
  logic [ADDR_WIDTH-1:0] addr_cut;
  logic [ADDR_WIDTH-1:0] set_sh;
  logic [ADDR_WIDTH-1:0] tag_sh;
  logic [SET_W-1:0]      set_mask;
  logic [SET_W-1:0]      set_in;
  logic [TAG_WIDTH-1:0]  tag_in;

  always_comb begin
    addr_cut = ADDR_WIDTH'(in_req.address);
    set_sh   = addr_cut >> block_bits_r;
    tag_sh   = addr_cut >> (SHIFT_W'(block_bits_r) + SHIFT_W'(sb_eff));
    set_mask = (SET_W'(1) << sb_eff) - SET_W'(1);
    set_in   = SET_W'(set_sh) & set_mask;
    tag_in   = TAG_WIDTH'(tag_sh);
  end

  // control and datapath registers
  state_t               state_r;
  logic [SET_W-1:0]     set_r;
  logic [TAG_WIDTH-1:0] tag_r;
  logic                 second_r;
  logic                 look_ok_r;
  pick_t                pick_r;
  logic [AGE_W-1:0]     age_clock_r;
  logic [COUNT_W-1:0]   hits_r;
  logic [COUNT_W-1:0]   misses_r;
  logic [COUNT_W-1:0]   evicts_r;
  logic [NUM_SETS-1:0]  row_ok_r;

  logic                 out_valid_r;
  logic [OUTCOME_W-1:0] out_outcome_r;
  logic [WAY_OUT_W-1:0] out_way_r;
  logic                 out_last_r;

  logic in_accept;
  logic out_free;
  logic ram_we;
  logic ram_re;
  logic [SET_W-1:0] ram_raddr;
  logic [ROW_W-1:0] row_rd;
  logic [ROW_W-1:0] row_cur;
  logic [ROW_W-1:0] row_wr;
  logic [LINE_W-1:0] new_line;

  logic [MAX_WAYS-1:0]                cur_valid;
  logic [MAX_WAYS-1:0][TAG_WIDTH-1:0] cur_tags;
  logic [MAX_WAYS-1:0][AGE_W-1:0]     cur_ages;
  pick_t                              pick;

  logic [COUNT_W-1:0] hits_nxt;
  logic [COUNT_W-1:0] misses_nxt;
  logic [COUNT_W-1:0] evicts_nxt;

  assign in_req.ready = (state_r == S_IDLE);
  assign in_accept    = in_req.valid && in_req.ready;
  assign out_free     = !out_valid_r || out_rsp.ready;
  assign ram_we       = (state_r == S_WRITE) && out_free;
  assign ram_re       = in_accept || (state_r == S_READ);
  assign ram_raddr    = (state_r == S_IDLE) ? set_in : set_r;

  salc_ram #(
    .WIDTH (ROW_W),
    .DEPTH (NUM_SETS)
  ) u_rows (
    .clk   (clk),
    .we    (ram_we),
    .waddr (set_r),
    .wdata (row_wr),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (row_rd)
  );

  // a row never written reads as all ways empty with zero age
  always_comb begin
    for (int w = 0; w < MAX_WAYS; w++) begin
      cur_valid[w] = look_ok_r && row_rd[w*LINE_W + LINE_W - 1];
      cur_tags[w]  = row_rd[w*LINE_W + AGE_W +: TAG_WIDTH];
      cur_ages[w]  = look_ok_r ? row_rd[w*LINE_W +: AGE_W] : '0;
      row_cur[w*LINE_W +: LINE_W] = {cur_valid[w], cur_tags[w], cur_ages[w]};
    end
  end

  salc_pick #(
    .MAX_WAYS  (MAX_WAYS),
    .TAG_WIDTH (TAG_WIDTH)
  ) u_pick (
    .valid (cur_valid),
    .tags  (cur_tags),
    .ages  (cur_ages),
    .tag   (tag_r),
    .ways  (ways_eff),
    .pick  (pick)
  );

  always_comb begin
    new_line = {1'b1, tag_r, age_clock_r + AGE_W'(1)};
    row_wr   = row_cur;
    for (int w = 0; w < MAX_WAYS; w++) begin
      if (pick_r.way == MAX_WAY_IDX_W'(w)) begin
        row_wr[w*LINE_W +: LINE_W] = new_line;
      end
    end
    hits_nxt   = hits_r   + COUNT_W'(pick_r.outcome == OUT_HIT);
    misses_nxt = misses_r + COUNT_W'(pick_r.outcome != OUT_HIT);
    evicts_nxt = evicts_r + COUNT_W'(pick_r.outcome == OUT_EVICT);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      second_r    <= 1'b0;
      row_ok_r    <= '0;
      age_clock_r <= '0;
      hits_r      <= '0;
      misses_r    <= '0;
      evicts_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // a write-back in the same cycle reloads the result register
      if (out_valid_r && out_rsp.ready && !ram_we) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_accept && kind_t'(in_req.kind) != KIND_NONE) begin
            set_r     <= set_in;
            tag_r     <= tag_in;
            look_ok_r <= row_ok_r[set_in];
            second_r  <= (kind_t'(in_req.kind) == KIND_MODIFY);
            state_r   <= S_EVAL;
          end
        end
        S_READ: begin
          look_ok_r <= row_ok_r[set_r];
          state_r   <= S_EVAL;
        end
        S_EVAL: begin
          pick_r  <= pick;
          state_r <= S_WRITE;
        end
        S_WRITE: begin
          if (out_free) begin
            row_ok_r[set_r] <= 1'b1;
            age_clock_r     <= age_clock_r + AGE_W'(1);
            hits_r          <= hits_nxt;
            misses_r        <= misses_nxt;
            evicts_r        <= evicts_nxt;
            out_valid_r     <= 1'b1;
            out_outcome_r   <= pick_r.outcome;
            out_way_r       <= WAY_OUT_W'(pick_r.way);
            out_last_r      <= !second_r;
            second_r        <= 1'b0;
            state_r         <= second_r ? S_READ : S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_rsp.valid          = out_valid_r;
  assign out_rsp.outcome        = out_outcome_r;
  assign out_rsp.way_used       = out_way_r;
  assign out_rsp.last           = out_last_r;
  assign out_rsp.hit_total      = hits_r;
  assign out_rsp.miss_total     = misses_r;
  assign out_rsp.eviction_total = evicts_r;

  // each write-back counts exactly one hit or one miss
  `SALC_ASSERT(a_count_step, clk, rst_n, ram_we |=> (hits_r + misses_r) == ($past(hits_r) + $past(misses_r) + 32'd1))
  // an eviction can only be chosen from a row that was written before
  `SALC_ASSERT(a_evict_row_ok, clk, rst_n, (state_r == S_EVAL && pick.outcome == OUT_EVICT) |-> look_ok_r)
  // the chosen way is always one of the ways in use
  `SALC_ASSERT(a_way_in_use, clk, rst_n, (state_r == S_EVAL) |-> (int'(pick.way) < int'(ways_eff)))
  // reset leaves the block idle with no result pending
  `SALC_ASSERT_ALL(a_reset_idle, clk, !rst_n |=> (state_r == S_IDLE && !out_valid_r && !second_r))
endmodule
`default_nettype wire

// File: sim/testbench.sv
// Testbench for the set-associative LRU cache: directed and random accesses checked per result
`default_nettype none
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import salc_pkg::*;

  localparam int NUM_LINES       = (1 << MAX_SET_BITS_D) * MAX_WAYS_D;
  localparam int SETTLE_CYCLES   = 8;
  localparam int RANDOM_PHASES   = 10;
  localparam int ITEMS_PER_PHASE = 150;
  localparam int REPORT_LIMIT    = 10;

  typedef struct packed {
    outcome_t               outcome;
    logic [WAY_OUT_W-1:0]   way_used;
    logic                   last;
    logic [COUNT_W-1:0]     hit_total;
    logic [COUNT_W-1:0]     miss_total;
    logic [COUNT_W-1:0]     eviction_total;
  } access_result_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  salc_req_if req_if();
  salc_rsp_if rsp_if();

  set_assoc_lru_cache_sim dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_req    (req_if.sink),
    .out_rsp   (rsp_if.source),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // behavioral copy of the cache
  bit                    line_present [NUM_LINES];
  logic [TAG_WIDTH_D-1:0] line_tag_copy [NUM_LINES];
  logic [AGE_W-1:0]      line_stamp [NUM_LINES];
  logic [AGE_W-1:0]      stamp_clock;
  logic [COUNT_W-1:0]    hits_seen;
  logic [COUNT_W-1:0]    misses_seen;
  logic [COUNT_W-1:0]    evictions_seen;
  logic [SET_BITS_W-1:0]   set_bits_r;
  logic [WAYS_W-1:0]       ways_r;
  logic [BLOCK_BITS_W-1:0] block_bits_r;

  access_result_t expected_results[$];
  int fail_count = 0;
  int stall_left = 0;
  bit no_gaps    = 1'b0;
  bit no_stalls  = 1'b0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #10ms;
    $display("testbench NOT OK");
    $finish;
  end

  function automatic int pick_gap();
    if ($urandom_range(9) == 0) return $urandom_range(8, 40);
    return $urandom_range(1, 3);
  endfunction

  function automatic int eff_set_bits();
    return (set_bits_r > MAX_SET_BITS_D) ? MAX_SET_BITS_D : int'(set_bits_r);
  endfunction

  function automatic int eff_ways();
    if (ways_r == 0) return 1;
    return (ways_r > MAX_WAYS_D) ? MAX_WAYS_D : int'(ways_r);
  endfunction

  function automatic void reset_cache_copy();
    for (int i = 0; i < NUM_LINES; i++) begin
      line_present[i]  = 1'b0;
      line_tag_copy[i] = '0;
      line_stamp[i]    = '0;
    end
    stamp_clock    = '0;
    hits_seen      = '0;
    misses_seen    = '0;
    evictions_seen = '0;
    set_bits_r     = SET_BITS_RST;
    ways_r         = WAYS_RST;
    block_bits_r   = BLOCK_BITS_RST;
  endfunction

  function automatic void lookup_and_fill(logic [63:0] addr, logic is_last);
    int sb, nways, base, way;
    bit found;
    logic [63:0] shifted;
    logic [63:0] set_idx;
    logic [TAG_WIDTH_D-1:0] tag;
    logic [AGE_W-1:0] oldest;
    outcome_t kind_of_result;
    access_result_t r;
    sb = eff_set_bits();
    nways = eff_ways();
    set_idx = (addr >> block_bits_r) & ((64'd1 << sb) - 64'd1);
    // shifts of 64 or more give zero here as in the cache
    shifted = addr >> (int'(block_bits_r) + sb);
    tag = shifted[TAG_WIDTH_D-1:0];
    base = int'(set_idx) * MAX_WAYS_D;
    found = 1'b0;
    way = 0;
    for (int w = 0; w < nways && !found; w++) begin
      if (line_present[base + w] && line_tag_copy[base + w] == tag) begin
        way = w;
        found = 1'b1;
      end
    end
    if (found) begin
      kind_of_result = OUT_HIT;
      hits_seen++;
    end else begin
      for (int w = 0; w < nways && !found; w++) begin
        if (!line_present[base + w]) begin
          way = w;
          found = 1'b1;
        end
      end
      misses_seen++;
      if (found) begin
        kind_of_result = OUT_FILL;
      end else begin
        oldest = line_stamp[base];
        way = 0;
        for (int w = 1; w < nways; w++) begin
          if (line_stamp[base + w] < oldest) begin
            oldest = line_stamp[base + w];
            way = w;
          end
        end
        kind_of_result = OUT_EVICT;
        evictions_seen++;
      end
    end
    stamp_clock++;
    line_present[base + way]  = 1'b1;
    line_tag_copy[base + way] = tag;
    line_stamp[base + way]    = stamp_clock;
    r.outcome        = kind_of_result;
    r.way_used       = WAY_OUT_W'(way);
    r.last           = is_last;
    r.hit_total      = hits_seen;
    r.miss_total     = misses_seen;
    r.eviction_total = evictions_seen;
    expected_results.push_back(r);
  endfunction

  function automatic void predict_item(kind_t k, logic [63:0] addr);
    case (k)
      KIND_LOAD, KIND_STORE: lookup_and_fill(addr, 1'b1);
      KIND_MODIFY: begin
        lookup_and_fill(addr, 1'b0);
        lookup_and_fill(addr, 1'b1);
      end
      default: ;
    endcase
  endfunction

  function automatic void report_failure(string msg);
    fail_count++;
    if (fail_count <= REPORT_LIMIT) $display("%s", msg);
  endfunction

  // result side: random stalls, some long
  always @(posedge clk) begin
    if (stall_left > 0) begin
      rsp_if.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      rsp_if.ready <= 1'b1;
      if (!no_stalls && $urandom_range(3) == 0) stall_left <= pick_gap();
    end
  end

  always @(posedge clk) begin
    access_result_t seen;
    access_result_t want;
    if (rst_n && rsp_if.valid && rsp_if.ready) begin
      seen = {rsp_if.outcome, rsp_if.way_used, rsp_if.last, rsp_if.hit_total,
              rsp_if.miss_total, rsp_if.eviction_total};
      if (expected_results.size() == 0) begin
        report_failure($sformatf("unexpected item: outcome %0d way %0d last %0d",
                                 seen.outcome, seen.way_used, seen.last));
      end else begin
        want = expected_results.pop_front();
        if (seen !== want)
          report_failure($sformatf({"mismatch: outcome %0d/%0d way %0d/%0d last %0d/%0d ",
                                    "hits %0d/%0d misses %0d/%0d evictions %0d/%0d ",
                                    "(expected/actual)"},
                                   want.outcome, seen.outcome, want.way_used, seen.way_used,
                                   want.last, seen.last, want.hit_total, seen.hit_total,
                                   want.miss_total, seen.miss_total,
                                   want.eviction_total, seen.eviction_total));
      end
    end
  end

  // called and returns at a rising edge; valid stays high after acceptance
  task automatic send_access(kind_t k, logic [63:0] addr);
    int gap;
    gap = (!no_gaps && $urandom_range(1) == 0) ? pick_gap() : 0;
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_if.valid   <= 1'b1;
    req_if.kind    <= k;
    req_if.address <= addr;
    do @(posedge clk); while (!req_if.ready);
    predict_item(k, addr);
  endtask

  task automatic drain_results();
    req_if.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    // an ignored item may still be in flight
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_config(logic [SET_BITS_W-1:0] sb, logic [WAYS_W-1:0] ways,
                            logic [BLOCK_BITS_W-1:0] bb);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_SET_BITS;
    cfg_wdata <= CFG_DATA_W'(sb);
    @(posedge clk);
    cfg_index <= CFG_WAYS;
    cfg_wdata <= CFG_DATA_W'(ways);
    @(posedge clk);
    cfg_index <= CFG_BLOCK_BITS;
    cfg_wdata <= CFG_DATA_W'(bb);
    @(posedge clk);
    cfg_we <= 1'b0;
    set_bits_r   = sb;
    ways_r       = ways;
    block_bits_r = bb;
  endtask

  // mostly a small tag pool in a few sets so hits and evictions are common
  function automatic logic [63:0] make_access_addr();
    logic [63:0] a;
    logic [TAG_WIDTH_D-1:0] tag;
    logic [MAX_SET_BITS_D-1:0] set_v;
    int sb, lsb;
    sb = eff_set_bits();
    a = {$urandom, $urandom};
    if ($urandom_range(4) == 0) return a;
    tag = $urandom_range(eff_ways() + 2);
    if ($urandom_range(7) == 0) tag = ~tag;
    set_v = MAX_SET_BITS_D'($urandom_range(3));
    lsb = int'(block_bits_r) + sb;
    for (int i = 0; i < sb; i++)
      if (int'(block_bits_r) + i < 64) a[int'(block_bits_r) + i] = set_v[i];
    for (int i = 0; i < TAG_WIDTH_D; i++)
      if (lsb + i < 64) a[lsb + i] = tag[i];
    return a;
  endfunction

  function automatic kind_t pick_kind();
    int r;
    r = $urandom_range(99);
    if (r < 35) return KIND_LOAD;
    if (r < 65) return KIND_STORE;
    if (r < 95) return KIND_MODIFY;
    return KIND_NONE;
  endfunction

  task automatic test_default_config();
    send_access(KIND_LOAD, 64'h0);
    send_access(KIND_LOAD, 64'hF);
    send_access(KIND_STORE, 64'h10);
    send_access(KIND_MODIFY, 64'h100);
    send_access(KIND_NONE, '1);
    send_access(KIND_LOAD, '1);
    // same tag and set, bits above the tag differ
    send_access(KIND_STORE, 64'h0000_00FF_FFFF_FFFF);
    drain_results();
  endtask

  task automatic test_register_extremes();
    // set bits and ways saturate, offset leaves only the top address bit
    set_config(3'd7, 4'd15, 6'd63);
    send_access(KIND_LOAD, 64'h8000_0000_0000_0000);
    send_access(KIND_LOAD, 64'h0);
    send_access(KIND_MODIFY, 64'h1);
    // zero ways acts as one
    set_config(3'd0, 4'd0, 6'd0);
    send_access(KIND_LOAD, 64'h5);
    send_access(KIND_LOAD, 64'h6);
    send_access(KIND_LOAD, 64'h6);
    set_config(3'd6, 4'd8, 6'd32);
    send_access(KIND_STORE, 64'hAAAA_5555_0F0F_F0F0);
  endtask

  task automatic test_lru_replacement();
    set_config(3'd0, 4'd4, 6'd0);
    send_access(KIND_LOAD, 64'h1);
    send_access(KIND_LOAD, 64'h2);
    send_access(KIND_LOAD, 64'h3);
    send_access(KIND_LOAD, 64'h6);
    send_access(KIND_LOAD, 64'h4);
    // shrink: upper ways keep their lines but are not searched
    set_config(3'd0, 4'd2, 6'd0);
    send_access(KIND_LOAD, 64'h3);
    set_config(3'd0, 4'd4, 6'd0);
    send_access(KIND_STORE, 64'h3);
    send_access(KIND_MODIFY, 64'h7);
    drain_results();
  endtask

  task automatic test_random_traffic();
    logic [SET_BITS_W-1:0]   sb;
    logic [WAYS_W-1:0]       ways;
    logic [BLOCK_BITS_W-1:0] bb;
    int r;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase)
        0: begin sb = 3'd1; ways = 4'd8; bb = 6'd0; end
        1: begin sb = 3'd0; ways = 4'd1; bb = 6'd0; end
        2: begin sb = 3'd7; ways = 4'd9; bb = 6'd2; end
        3: begin sb = 3'd6; ways = 4'd8; bb = 6'd32; end
        default: begin
          sb = SET_BITS_W'($urandom_range(7));
          ways = WAYS_W'($urandom_range(15));
          r = $urandom_range(9);
          bb = BLOCK_BITS_W'((r < 7) ? $urandom_range(8)
                                     : (r < 9) ? $urandom_range(9, 40)
                                               : $urandom_range(41, 63));
        end
      endcase
      set_config(sb, ways, bb);
      no_gaps   = (phase == 0) || ($urandom_range(4) == 0);
      no_stalls = (phase == 0) || ($urandom_range(4) == 0);
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        // sender holds off until every result is back
        if ((i == ITEMS_PER_PHASE / 2 && phase % 3 == 0) || $urandom_range(199) == 0)
          drain_results();
        send_access(pick_kind(), make_access_addr());
      end
    end
    no_gaps   = 1'b0;
    no_stalls = 1'b0;
    drain_results();
  endtask

  initial begin
    rst_n          <= 1'b0;
    cfg_we         <= 1'b0;
    cfg_index      <= CFG_SET_BITS;
    cfg_wdata      <= '0;
    req_if.valid   <= 1'b0;
    req_if.kind    <= KIND_LOAD;
    req_if.address <= '0;
    reset_cache_copy();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    test_default_config();
    test_register_extremes();
    test_lru_replacement();
    test_random_traffic();
    drain_results();
    if (fail_count == 0 && expected_results.size() == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
`default_nettype wire
